// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dsf_pkg.sv =====
package dsf_pkg;

  localparam int MAX_SIDE  = 64;
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int POS_W     = $clog2(MAX_SIDE);
  localparam int ADDR_W    = 2 * POS_W;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int HEIGHT_W  = 8;
  localparam int WEIGHT_W  = 9;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = WEIGHT_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(256);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(128);
  localparam logic [SIDE_W-1:0]   SIDE_MIN     = SIDE_W'(2);
  localparam logic [SIDE_W-1:0]   SIDE_MAX     = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0]   SIDE_RESET   = SIDE_W'(MAX_SIDE);

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 1'b1;

  localparam logic [CMD_W-1:0] CMD_WR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RD   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   cell_index;
    logic [HEIGHT_W-1:0] height_in;
  } dsf_in_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height_out;
    logic                filter_done;
  } dsf_out_t;

endpackage

// ===== hw/rtl/dsf_ram.sv =====
module dsf_ram
  import dsf_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [HEIGHT_W-1:0] wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [HEIGHT_W-1:0] rdata
);

  logic [HEIGHT_W-1:0] mem [DEPTH];
  logic [HEIGHT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dsf_blend.sv =====
module dsf_blend
  import dsf_pkg::*;
(
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [HEIGHT_W-1:0] prev,
  input  logic [HEIGHT_W-1:0] cur,
  output logic [HEIGHT_W-1:0] result
);

  // The blend is rewritten as cur + floor(weight * (prev - cur) / 256).
  logic signed [HEIGHT_W:0]              diff;
  logic signed [WEIGHT_W+HEIGHT_W+1:0]   prod;

  always_comb begin
    diff   = $signed({1'b0, prev}) - $signed({1'b0, cur});
    prod   = $signed({1'b0, weight}) * diff;
    result = cur + prod[HEIGHT_W+7:8];
  end

endmodule

// ===== hw/rtl/directional_smoothing_filter.sv =====
// Channel   Ports                                    Transaction
// input     start, busy, in_data                     start high while busy low
// result    out_valid, out_data                      out_valid high for one cycle
// config    cfg_we, cfg_index, cfg_wdata             cfg_we high at the clock edge
//
// A write or unused command gives its result in the cycle after acceptance.
// A read holds busy in the READ state and gives its result from the output register after it.
// A filter is busy for a priming state and four grid passes, one cell per cycle
// through the single read port and single write port of the height memory.
// Reset is synchronous and active low; the height memory is not cleared.
// The receiver cannot stall, so results are never held back.
module directional_smoothing_filter
  import dsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dsf_in_t              in_data,
  output logic                 out_valid,
  output dsf_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_PRIME = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          dir_r, dir_nxt;
  logic [POS_W-1:0]    line_r, line_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [HEIGHT_W-1:0] prev_r, prev_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic                range_r, range_nxt;
  logic                out_valid_r, out_valid_nxt;
  dsf_out_t            out_data_r, out_data_nxt;
  logic [WEIGHT_W-1:0] weight_r;
  logic [SIDE_W-1:0]   side_r;

  logic [SIDE_W-1:0]   side_eff;
  logic [SIDE_W-1:0]   side_m1;
  logic [POS_W-1:0]    last_pos;
  logic [2*SIDE_W-1:0] limit;
  logic                in_range;
  logic                accept;
  logic [POS_W-1:0]    row, col;
  logic [ADDR_W:0]     row_base;
  logic [ADDR_W:0]     addr_sum;
  logic [ADDR_W-1:0]   cell_addr;
  logic                final_cell;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [HEIGHT_W-1:0] ram_wdata, ram_rdata;
  logic [HEIGHT_W-1:0] blend_out;

  always_comb begin
    if (side_r < SIDE_MIN) begin
      side_eff = SIDE_MIN;
    end else if (side_r > SIDE_MAX) begin
      side_eff = SIDE_MAX;
    end else begin
      side_eff = side_r;
    end
    side_m1  = side_eff - SIDE_W'(1);
    last_pos = side_m1[POS_W-1:0];
    limit    = {{SIDE_W{1'b0}}, side_eff} * {{SIDE_W{1'b0}}, side_eff};
    in_range = {{(2*SIDE_W-ADDR_W){1'b0}}, in_data.cell_index} < limit;
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
      side_r   <= SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WEIGHT: begin
          weight_r <= (cfg_wdata > WEIGHT_ONE) ? WEIGHT_ONE : cfg_wdata;
        end
        REG_SIDE: begin
          side_r <= cfg_wdata[SIDE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign final_cell = (dir_r == 2'd3) && (line_r == last_pos) && (pos_r == last_pos);

  always_comb begin
    state_nxt     = state_r;
    dir_nxt       = dir_r;
    line_nxt      = line_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    range_nxt     = range_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.cmd) inside
            CMD_FILT: begin
              dir_nxt   = 2'd0;
              line_nxt  = '0;
              pos_nxt   = '0;
              state_nxt = S_PRIME;
            end
            CMD_RD: begin
              range_nxt = in_range;
              state_nxt = S_READ;
            end
            CMD_WR, CMD_NOP: begin
              out_valid_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.height_out = range_r ? ram_rdata : '0;
        state_nxt               = S_IDLE;
      end
      S_PRIME: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        prev_nxt = (pos_r == '0) ? ram_rdata : blend_out;
        if (final_cell) begin
          dir_nxt                  = 2'd0;
          line_nxt                 = '0;
          pos_nxt                  = '0;
          prev_nxt                 = '0;
          out_valid_nxt            = 1'b1;
          out_data_nxt.filter_done = 1'b1;
          state_nxt                = S_IDLE;
        end else if (pos_r == last_pos) begin
          pos_nxt = '0;
          if (line_r == last_pos) begin
            line_nxt = '0;
            dir_nxt  = dir_r + 2'd1;
          end else begin
            line_nxt = line_r + POS_W'(1);
          end
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    case (dir_nxt)
      2'd0: begin
        row = line_nxt;
        col = pos_nxt;
      end
      2'd1: begin
        row = line_nxt;
        col = last_pos - pos_nxt;
      end
      2'd2: begin
        row = pos_nxt;
        col = line_nxt;
      end
      default: begin
        row = last_pos - pos_nxt;
        col = line_nxt;
      end
    endcase
    row_base  = {{(ADDR_W+1-POS_W){1'b0}}, row} * {{(ADDR_W+1-SIDE_W){1'b0}}, side_eff};
    addr_sum  = row_base + {{(ADDR_W+1-POS_W){1'b0}}, col};
    cell_addr = addr_sum[ADDR_W-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_data.cell_index;
    ram_wdata = in_data.height_in;
    ram_re    = 1'b0;
    ram_raddr = in_data.cell_index;
    addr_nxt  = addr_r;
    if (state_r == S_IDLE) begin
      ram_we = accept && (in_data.cmd == CMD_WR) && in_range;
      ram_re = accept && (in_data.cmd == CMD_RD);
    end else if ((state_r == S_PRIME) || ((state_r == S_RUN) && !final_cell)) begin
      ram_re    = 1'b1;
      ram_raddr = cell_addr;
      addr_nxt  = cell_addr;
    end
    if ((state_r == S_RUN) && (pos_r != '0)) begin
      ram_we    = 1'b1;
      ram_waddr = addr_r;
      ram_wdata = blend_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= 2'd0;
      line_r      <= '0;
      pos_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      line_r      <= line_nxt;
      pos_r       <= pos_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    range_r    <= range_nxt;
    out_data_r <= out_data_nxt;
  end

  dsf_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dsf_blend u_blend (
    .weight (weight_r),
    .prev   (prev_r),
    .cur    (ram_rdata),
    .result (blend_out)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/dsf_checker.sv =====
`include "assert_macros.svh"

module dsf_checker
  import dsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  dsf_in_t              in_data,
  input  logic                 out_valid,
  input  dsf_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic acc_wr, acc_rd, acc_filt;

  assign acc_wr     = start && !busy && ((in_data.cmd == CMD_WR) || (in_data.cmd == CMD_NOP));
  assign acc_rd     = start && !busy && (in_data.cmd == CMD_RD);
  assign acc_filt   = start && !busy && (in_data.cmd == CMD_FILT);

  `ASSERT_NEXT(a_write_result, clk, rst_n, acc_wr,
    out_valid && !out_data.filter_done && (out_data.height_out == '0) && !busy,
    "write transaction did not give a zero result in the next cycle")
  `ASSERT_NEXT(a_read_result, clk, rst_n, acc_rd,
    busy && !out_valid ##1 out_valid && !out_data.filter_done,
    "read transaction result not two cycles after acceptance")
  `ASSERT_NEXT(a_filter_busy, clk, rst_n, acc_filt, busy && !out_valid,
    "filter transaction did not hold busy")
  `ASSERT_SAME(a_done_fields, clk, rst_n, out_valid && out_data.filter_done,
    (out_data.height_out == '0) && $past(busy),
    "filter result carries a nonzero height")
  `ASSERT_SAME(a_cfg_idle, clk, rst_n, cfg_we,
    !busy && !$isunknown(cfg_index) && !$isunknown(cfg_wdata),
    "configuration written while a transaction is in flight")

endmodule

bind directional_smoothing_filter dsf_checker u_dsf_checker (.*);
